// File: sv/mhl_pkg.sv
// ============================================================================
// mhl_pkg: shared definitions for the hidden layer evaluator
// Field widths, codes, sequencer types and the sigmoid table procedure.
// ============================================================================
`default_nettype none

package mhl_pkg;

   localparam int CMD_W      = 1;
   localparam int WIDX_W     = 9;
   localparam int VALUE_W    = 16;
   localparam int OUT_W      = 32;
   localparam int VCNT_W     = 5;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 15;
   localparam int DIM_W      = 5;
   localparam int LIMIT_W    = 15;
   localparam int ARG_W      = 40;
   localparam int SUM_W      = 48;
   localparam int MUL_B_W    = 17;
   localparam int PROD_W     = 33;
   localparam int ROM_W      = 16;
   localparam int FRAC_W     = 12;
   localparam int SIG_SHIFT  = 16;
   localparam int ARG_SPAN_LOG = 28;

   localparam int MAX_INPUTS_DEF      = 16;
   localparam int MAX_NODES_DEF       = 16;
   localparam int SIGMOID_ENTRIES_DEF = 256;

   localparam logic [DIM_W-1:0]   DIM_RESET   = DIM_W'(1);
   localparam logic [DIM_W-1:0]   NODES_RESET = DIM_W'(1);
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(32767);

   localparam logic CMD_WEIGHT = 1'b0;
   localparam logic CMD_SAMPLE = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_DIMENSION = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_NODES     = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT     = CSR_IDX_W'(2);

   localparam logic signed [ARG_W-1:0] ARG_LO = -(ARG_W'(1) << (ARG_SPAN_LOG - 1));
   localparam logic signed [ARG_W-1:0] ARG_HI = ARG_W'(1) << (ARG_SPAN_LOG - 1);

   localparam logic signed [SUM_W-1:0] SAT_HI = (SUM_W'(1) << (OUT_W - 1)) - SUM_W'(1);
   localparam logic signed [SUM_W-1:0] SAT_LO = -(SUM_W'(1) << (OUT_W - 1));

   localparam logic signed [MUL_B_W-1:0] BIAS_SCALE = MUL_B_W'(1) << FRAC_W;

   localparam logic [63:0] ONE_Q32 = 64'd1 << 32;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_DRAIN,
      ST_ACT,
      ST_OUTMUL,
      ST_OUTACC,
      ST_FINISH
   } state_type;

   typedef enum logic [1:0] {
      TAG_NONE,
      TAG_OW,
      TAG_MAC,
      TAG_BIAS
   } tag_type;

   typedef enum logic {
      DEST_ARG,
      DEST_SUM
   } dest_type;

   typedef struct packed {
      logic     mul_valid;
      dest_type dest;
      logic     clear_arg;
      logic     clear_sum;
   } mac_ctrl_type;

   function automatic logic [63:0] mul_q32(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return p[95:32];
   endfunction

   // Restoring shift and subtract division, used only while the table is built.
   function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
      logic [64:0] rem;
      logic [63:0] quo;
      rem = '0;
      quo = '0;
      for (int i = 63; i >= 0; i--) begin
         rem = {rem[63:0], num[i]};
         if (rem >= {1'b0, den}) begin
            rem    = rem - {1'b0, den};
            quo[i] = 1'b1;
         end
      end
      return quo;
   endfunction

   // Table entry k of n: sigmoid at the centre of bin k over [-8, 8), in Q0.16.
   function automatic logic [ROM_W-1:0] sigmoid_entry(input int k, input int n);
      longint     m;
      logic [63:0] mag;
      logic [63:0] f;
      logic [63:0] term;
      logic [63:0] e;
      logic [63:0] den;
      logic [63:0] num;
      logic [63:0] val;
      m = 2 * longint'(k) + 1 - longint'(n);
      mag = (m < 0) ? 64'(-m) : 64'(m);
      f = div_u64(mag << 32, 64'(n));
      term = ONE_Q32;
      e = ONE_Q32;
      for (int t = 1; t <= 30; t++) begin
         term = div_u64(mul_q32(term, f), 64'(t));
         e = e + term;
      end
      e = mul_q32(e, e);
      e = mul_q32(e, e);
      e = mul_q32(e, e);
      den = e + ONE_Q32;
      num = (m > 0) ? e : ONE_Q32;
      val = div_u64(num * 64'd65536 + (den >> 1), den);
      return (val > 64'd65535) ? 16'hFFFF : val[ROM_W-1:0];
   endfunction

endpackage

`default_nettype wire

// File: sv/mhl_req_if.sv
// ============================================================================
// mhl_req_if: request channel
// Carries weight writes and sample elements with a valid and ready transfer.
// ============================================================================
`default_nettype none

interface mhl_req_if;
   logic                               valid;
   logic                               ready;
   logic                               command;
   logic [mhl_pkg::WIDX_W-1:0]         weight_index;
   logic signed [mhl_pkg::VALUE_W-1:0] weight_value;
   logic signed [mhl_pkg::VALUE_W-1:0] sample_value;
   logic                               last_element;

   modport source (
      output valid, command, weight_index, weight_value, sample_value, last_element,
      input  ready
   );

   modport sink (
      input  valid, command, weight_index, weight_value, sample_value, last_element,
      output ready
   );
endinterface

`default_nettype wire

// File: sv/mhl_rsp_if.sv
// ============================================================================
// mhl_rsp_if: response channel
// Carries the network output and violation count with a valid and ready transfer.
// ============================================================================
`default_nettype none

interface mhl_rsp_if;
   logic                             valid;
   logic                             ready;
   logic signed [mhl_pkg::OUT_W-1:0] network_output;
   logic [mhl_pkg::VCNT_W-1:0]       violation_count;

   modport source (
      output valid, network_output, violation_count,
      input  ready
   );

   modport sink (
      input  valid, network_output, violation_count,
      output ready
   );
endinterface

`default_nettype wire

// File: sv/mhl_weight_ram.sv
// ============================================================================
// mhl_weight_ram: weight table
// Single write port and one registered read port.
// ============================================================================
`default_nettype none

module mhl_weight_ram #(
   parameter int DEPTH = mhl_pkg::MAX_NODES_DEF * (mhl_pkg::MAX_INPUTS_DEF + 2),
   parameter int AW    = $clog2(DEPTH)
) (
   input  wire logic                               clock,
   input  wire logic                               wr_en,
   input  wire logic [AW-1:0]                      wr_addr,
   input  wire logic signed [mhl_pkg::VALUE_W-1:0] wr_data,
   input  wire logic [AW-1:0]                      rd_addr,
   output      logic signed [mhl_pkg::VALUE_W-1:0] rd_data
);

   logic signed [mhl_pkg::VALUE_W-1:0] mem [DEPTH];
   logic signed [mhl_pkg::VALUE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: sv/mhl_sigmoid_rom.sv
// ============================================================================
// mhl_sigmoid_rom: sigmoid lookup table
// Constant Q0.16 table over [-8, 8), built at elaboration, registered read.
// ============================================================================
`default_nettype none

module mhl_sigmoid_rom #(
   parameter int ENTRIES = mhl_pkg::SIGMOID_ENTRIES_DEF,
   parameter int AW      = $clog2(ENTRIES)
) (
   input  wire logic                        clock,
   input  wire logic [AW-1:0]               addr,
   output      logic [mhl_pkg::ROM_W-1:0]   data
);

   logic [mhl_pkg::ROM_W-1:0] rom_arr [ENTRIES];
   logic [mhl_pkg::ROM_W-1:0] data_ff;

   for (genvar k = 0; k < ENTRIES; k++) begin : g_rom
      localparam logic [mhl_pkg::ROM_W-1:0] ENTRY = mhl_pkg::sigmoid_entry(k, ENTRIES);
      assign rom_arr[k] = ENTRY;
   end

   always_ff @(posedge clock) begin
      data_ff <= rom_arr[addr];
   end

   assign data = data_ff;

endmodule

`default_nettype wire

// File: sv/mhl_mac_unit.sv
// ============================================================================
// mhl_mac_unit: shared multiply and accumulate unit
// One registered multiplier feeding the node argument or the output sum.
// ============================================================================
`default_nettype none

module mhl_mac_unit (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire mhl_pkg::mac_ctrl_type               ctrl,
   input  wire logic signed [mhl_pkg::VALUE_W-1:0]  op_a,
   input  wire logic signed [mhl_pkg::MUL_B_W-1:0]  op_b,
   output      logic signed [mhl_pkg::ARG_W-1:0]    arg,
   output      logic signed [mhl_pkg::SUM_W-1:0]    sum,
   output      logic                                busy
);

   logic signed [mhl_pkg::PROD_W-1:0] prod_ff;
   logic signed [mhl_pkg::PROD_W-1:0] prod_in;
   logic                              prod_valid_ff;
   mhl_pkg::dest_type                 dest_ff;
   logic signed [mhl_pkg::ARG_W-1:0]  arg_ff;
   logic signed [mhl_pkg::ARG_W-1:0]  arg_in;
   logic signed [mhl_pkg::SUM_W-1:0]  sum_ff;
   logic signed [mhl_pkg::SUM_W-1:0]  sum_in;

   assign prod_in = mhl_pkg::PROD_W'(op_a) * mhl_pkg::PROD_W'(op_b);

   always_comb begin
      if (ctrl.clear_arg) begin
         arg_in = '0;
      end else if (prod_valid_ff && dest_ff == mhl_pkg::DEST_ARG) begin
         arg_in = arg_ff + mhl_pkg::ARG_W'(prod_ff);
      end else begin
         arg_in = arg_ff;
      end
      if (ctrl.clear_sum) begin
         sum_in = '0;
      end else if (prod_valid_ff && dest_ff == mhl_pkg::DEST_SUM) begin
         sum_in = sum_ff + mhl_pkg::SUM_W'(prod_ff);
      end else begin
         sum_in = sum_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         dest_ff       <= mhl_pkg::DEST_ARG;
         arg_ff        <= '0;
         sum_ff        <= '0;
      end else begin
         prod_valid_ff <= ctrl.mul_valid;
         dest_ff       <= ctrl.dest;
         arg_ff        <= arg_in;
         sum_ff        <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign arg  = arg_ff;
   assign sum  = sum_ff;
   assign busy = prod_valid_ff;

endmodule

`default_nettype wire

// File: sv/mlp_hidden_layer_eval_top.sv
// ============================================================================
// mlp_hidden_layer_eval_top: one hidden layer sigmoid network evaluator
// Weight table, sample buffer, sequencer and one shared multiply unit.
// ============================================================================
// Weight writes and sample elements other than the last are taken back to back while idle.
// A last element starts an evaluation paced by the single shared multiplier:
// D + 2 table reads per node, then a pipeline drain, the sigmoid lookup and
// the output product. Ready stays low meanwhile.
// Reset is synchronous: registers return to D = 1, one node and a full limit;
// the weight table and sample buffer hold undefined data until written.
`default_nettype none

module mlp_hidden_layer_eval_top #(
   parameter int MAX_INPUTS      = mhl_pkg::MAX_INPUTS_DEF,
   parameter int MAX_NODES       = mhl_pkg::MAX_NODES_DEF,
   parameter int SIGMOID_ENTRIES = mhl_pkg::SIGMOID_ENTRIES_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   mhl_req_if.sink                                 req_chan,
   mhl_rsp_if.source                               rsp_chan,
   input  wire logic                               csr_wr_en,
   input  wire logic [mhl_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [mhl_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int DEPTH   = MAX_NODES * (MAX_INPUTS + 2);
   localparam int AW      = $clog2(DEPTH);
   localparam int CNT_W   = $clog2(MAX_INPUTS + 1);
   localparam int SAW     = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
   localparam int J_W     = $clog2(MAX_INPUTS + 2);
   localparam int NODE_W  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int VC_W    = $clog2(MAX_NODES + 1);
   localparam int RIW     = $clog2(SIGMOID_ENTRIES);
   localparam int IPW     = mhl_pkg::ARG_SPAN_LOG + $clog2(SIGMOID_ENTRIES + 1);

   mhl_pkg::state_type state_ff, state_in;

   logic [mhl_pkg::DIM_W-1:0]   csr_dim_ff, csr_dim_in;
   logic [mhl_pkg::DIM_W-1:0]   csr_nodes_ff, csr_nodes_in;
   logic [mhl_pkg::LIMIT_W-1:0] csr_limit_ff, csr_limit_in;

   logic [CNT_W-1:0]  element_count_ff, element_count_in;
   logic [AW-1:0]     base_ff, base_in;
   logic [J_W-1:0]    j_ff, j_in;
   logic [NODE_W-1:0] node_ff, node_in;
   logic [VC_W-1:0]   viol_ff, viol_in;
   mhl_pkg::tag_type  tag1_ff, tag1_in;
   logic signed [mhl_pkg::VALUE_W-1:0] ow_ff, ow_in;

   logic                               rsp_valid_ff, rsp_valid_in;
   logic signed [mhl_pkg::OUT_W-1:0]   rsp_output_ff, rsp_output_in;
   logic [mhl_pkg::VCNT_W-1:0]         rsp_count_ff, rsp_count_in;

   logic signed [mhl_pkg::VALUE_W-1:0] sample_mem [MAX_INPUTS];
   logic signed [mhl_pkg::VALUE_W-1:0] sample_q_ff;
   logic [SAW-1:0]                     sample_rd_addr;
   logic                               sample_wr_en;

   logic [CNT_W-1:0] d_use;
   logic [VC_W-1:0]  nodes_use;
   logic [AW-1:0]    step;

   logic req_ready, req_fire, sample_fire, weight_fire, start;
   logic issue_en, clear_arg, act_en, out_mul, node_done, load_rsp;
   logic last_issue, last_node, pipe_empty, rsp_free;

   logic                               ram_wr_en;
   logic [AW-1:0]                      ram_rd_addr;
   logic signed [mhl_pkg::VALUE_W-1:0] ram_rd_data;

   logic [RIW-1:0]             rom_addr;
   logic [mhl_pkg::ROM_W-1:0]  rom_data;

   mhl_pkg::mac_ctrl_type                 mac_ctrl;
   logic signed [mhl_pkg::VALUE_W-1:0]    mac_a;
   logic signed [mhl_pkg::MUL_B_W-1:0]    mac_b;
   logic signed [mhl_pkg::ARG_W-1:0]      mac_arg;
   logic signed [mhl_pkg::SUM_W-1:0]      mac_sum;
   logic                                  mac_busy;

   logic [mhl_pkg::ARG_W-1:0]          arg_mag;
   logic [mhl_pkg::ARG_W-1:0]          limit_scaled;
   logic                               violation;
   logic [mhl_pkg::ARG_SPAN_LOG-1:0]   arg_off;
   logic [IPW-1:0]                     idx_prod;
   logic signed [mhl_pkg::SUM_W-1:0]   sum_sh;
   logic signed [mhl_pkg::OUT_W-1:0]   sum_sat;

   // Register values out of range are clamped when used.
   always_comb begin
      if (csr_dim_ff == '0) begin
         d_use = CNT_W'(1);
      end else if (32'(csr_dim_ff) > 32'(MAX_INPUTS)) begin
         d_use = CNT_W'(MAX_INPUTS);
      end else begin
         d_use = CNT_W'(csr_dim_ff);
      end
      if (csr_nodes_ff == '0) begin
         nodes_use = VC_W'(1);
      end else if (32'(csr_nodes_ff) > 32'(MAX_NODES)) begin
         nodes_use = VC_W'(MAX_NODES);
      end else begin
         nodes_use = VC_W'(csr_nodes_ff);
      end
   end

   assign step        = AW'(d_use) + AW'(2);
   assign req_fire    = req_chan.valid && req_ready;
   assign sample_fire = req_fire && req_chan.command == mhl_pkg::CMD_SAMPLE;
   assign weight_fire = req_fire && req_chan.command == mhl_pkg::CMD_WEIGHT;
   assign start       = sample_fire && req_chan.last_element;
   assign last_issue  = 32'(j_ff) == 32'(d_use) + 32'd1;
   assign last_node   = 32'(node_ff) + 32'd1 == 32'(nodes_use);
   assign pipe_empty  = tag1_ff == mhl_pkg::TAG_NONE && !mac_busy;
   assign rsp_free    = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mhl_pkg::ST_IDLE: begin
            if (start) begin
               state_in = mhl_pkg::ST_ISSUE;
            end
         end
         mhl_pkg::ST_ISSUE: begin
            if (last_issue) begin
               state_in = mhl_pkg::ST_DRAIN;
            end
         end
         mhl_pkg::ST_DRAIN: begin
            if (pipe_empty) begin
               state_in = mhl_pkg::ST_ACT;
            end
         end
         mhl_pkg::ST_ACT: begin
            state_in = mhl_pkg::ST_OUTMUL;
         end
         mhl_pkg::ST_OUTMUL: begin
            state_in = mhl_pkg::ST_OUTACC;
         end
         mhl_pkg::ST_OUTACC: begin
            state_in = last_node ? mhl_pkg::ST_FINISH : mhl_pkg::ST_ISSUE;
         end
         mhl_pkg::ST_FINISH: begin
            if (rsp_free) begin
               state_in = mhl_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mhl_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      issue_en  = 1'b0;
      clear_arg = 1'b0;
      act_en    = 1'b0;
      out_mul   = 1'b0;
      node_done = 1'b0;
      load_rsp  = 1'b0;
      case (state_ff)
         mhl_pkg::ST_IDLE: begin
            req_ready = 1'b1;
         end
         mhl_pkg::ST_ISSUE: begin
            issue_en  = 1'b1;
            clear_arg = j_ff == '0;
         end
         mhl_pkg::ST_ACT: begin
            act_en = 1'b1;
         end
         mhl_pkg::ST_OUTMUL: begin
            out_mul = 1'b1;
         end
         mhl_pkg::ST_OUTACC: begin
            node_done = 1'b1;
         end
         mhl_pkg::ST_FINISH: begin
            load_rsp = rsp_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_comb begin
      csr_dim_in   = csr_dim_ff;
      csr_nodes_in = csr_nodes_ff;
      csr_limit_in = csr_limit_ff;
      if (csr_wr_en) begin
         case (csr_index)
            mhl_pkg::CSR_DIMENSION: csr_dim_in   = csr_wdata[mhl_pkg::DIM_W-1:0];
            mhl_pkg::CSR_NODES:     csr_nodes_in = csr_wdata[mhl_pkg::DIM_W-1:0];
            mhl_pkg::CSR_LIMIT:     csr_limit_in = csr_wdata[mhl_pkg::LIMIT_W-1:0];
            default:                csr_limit_in = csr_limit_ff;
         endcase
      end
   end

   always_comb begin
      element_count_in = element_count_ff;
      if (sample_fire) begin
         if (req_chan.last_element) begin
            element_count_in = '0;
         end else if (32'(element_count_ff) < 32'(MAX_INPUTS)) begin
            element_count_in = element_count_ff + CNT_W'(1);
         end
      end
   end

   assign sample_wr_en   = sample_fire && 32'(element_count_ff) < 32'(MAX_INPUTS);
   assign ram_wr_en      = weight_fire && 32'(req_chan.weight_index) < 32'(DEPTH);
   assign ram_rd_addr    = base_ff + AW'(j_ff);
   assign sample_rd_addr = SAW'(j_ff - J_W'(1));

   always_comb begin
      if (!issue_en) begin
         tag1_in = mhl_pkg::TAG_NONE;
      end else if (j_ff == '0) begin
         tag1_in = mhl_pkg::TAG_OW;
      end else if (last_issue) begin
         tag1_in = mhl_pkg::TAG_BIAS;
      end else begin
         tag1_in = mhl_pkg::TAG_MAC;
      end

      j_in = j_ff;
      if (issue_en) begin
         j_in = last_issue ? '0 : j_ff + J_W'(1);
      end

      base_in = base_ff;
      node_in = node_ff;
      if (start) begin
         base_in = '0;
         node_in = '0;
      end else if (node_done && !last_node) begin
         base_in = base_ff + step;
         node_in = node_ff + NODE_W'(1);
      end

      viol_in = viol_ff;
      if (start) begin
         viol_in = '0;
      end else if (act_en && violation) begin
         viol_in = viol_ff + VC_W'(1);
      end

      ow_in = (tag1_ff == mhl_pkg::TAG_OW) ? ram_rd_data : ow_ff;
   end

   always_comb begin
      if (out_mul) begin
         mac_a = ow_ff;
         mac_b = $signed({1'b0, rom_data});
      end else begin
         mac_a = ram_rd_data;
         mac_b = (tag1_ff == mhl_pkg::TAG_BIAS) ? mhl_pkg::BIAS_SCALE
                                                : mhl_pkg::MUL_B_W'(sample_q_ff);
      end
      mac_ctrl.mul_valid = out_mul || tag1_ff == mhl_pkg::TAG_MAC
                           || tag1_ff == mhl_pkg::TAG_BIAS;
      mac_ctrl.dest      = out_mul ? mhl_pkg::DEST_SUM : mhl_pkg::DEST_ARG;
      mac_ctrl.clear_arg = clear_arg;
      mac_ctrl.clear_sum = start;
   end

   always_comb begin
      arg_mag      = mac_arg[mhl_pkg::ARG_W-1] ? mhl_pkg::ARG_W'(-mac_arg)
                                               : mhl_pkg::ARG_W'(mac_arg);
      limit_scaled = mhl_pkg::ARG_W'(csr_limit_ff) << mhl_pkg::FRAC_W;
      violation    = arg_mag >= limit_scaled;
      arg_off      = mhl_pkg::ARG_SPAN_LOG'(mac_arg - mhl_pkg::ARG_LO);
      idx_prod     = IPW'(arg_off) * IPW'(SIGMOID_ENTRIES);
      if (mac_arg < mhl_pkg::ARG_LO) begin
         rom_addr = '0;
      end else if (mac_arg >= mhl_pkg::ARG_HI) begin
         rom_addr = RIW'(SIGMOID_ENTRIES - 1);
      end else begin
         rom_addr = RIW'(idx_prod >> mhl_pkg::ARG_SPAN_LOG);
      end
   end

   assign sum_sh = mac_sum >>> mhl_pkg::SIG_SHIFT;

   always_comb begin
      if (sum_sh > mhl_pkg::SAT_HI) begin
         sum_sat = mhl_pkg::OUT_W'(mhl_pkg::SAT_HI);
      end else if (sum_sh < mhl_pkg::SAT_LO) begin
         sum_sat = mhl_pkg::OUT_W'(mhl_pkg::SAT_LO);
      end else begin
         sum_sat = mhl_pkg::OUT_W'(sum_sh);
      end
      rsp_output_in = load_rsp ? sum_sat : rsp_output_ff;
      rsp_count_in  = load_rsp ? mhl_pkg::VCNT_W'(viol_ff) : rsp_count_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= mhl_pkg::ST_IDLE;
         csr_dim_ff       <= mhl_pkg::DIM_RESET;
         csr_nodes_ff     <= mhl_pkg::NODES_RESET;
         csr_limit_ff     <= mhl_pkg::LIMIT_RESET;
         element_count_ff <= '0;
         base_ff          <= '0;
         j_ff             <= '0;
         node_ff          <= '0;
         viol_ff          <= '0;
         tag1_ff          <= mhl_pkg::TAG_NONE;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         csr_dim_ff       <= csr_dim_in;
         csr_nodes_ff     <= csr_nodes_in;
         csr_limit_ff     <= csr_limit_in;
         element_count_ff <= element_count_in;
         base_ff          <= base_in;
         j_ff             <= j_in;
         node_ff          <= node_in;
         viol_ff          <= viol_in;
         tag1_ff          <= tag1_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ow_ff         <= ow_in;
      rsp_output_ff <= rsp_output_in;
      rsp_count_ff  <= rsp_count_in;
      if (sample_wr_en) begin
         sample_mem[element_count_ff[SAW-1:0]] <= req_chan.sample_value;
      end
      sample_q_ff <= sample_mem[sample_rd_addr];
   end

   mhl_weight_ram #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_weight_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (AW'(req_chan.weight_index)),
      .wr_data (req_chan.weight_value),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   mhl_sigmoid_rom #(
      .ENTRIES (SIGMOID_ENTRIES),
      .AW      (RIW)
   ) u_sigmoid_rom (
      .clock (clock),
      .addr  (rom_addr),
      .data  (rom_data)
   );

   mhl_mac_unit u_mac_unit (
      .clock (clock),
      .reset (reset),
      .ctrl  (mac_ctrl),
      .op_a  (mac_a),
      .op_b  (mac_b),
      .arg   (mac_arg),
      .sum   (mac_sum),
      .busy  (mac_busy)
   );

   assign req_chan.ready           = req_ready;
   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.network_output  = rsp_output_ff;
   assign rsp_chan.violation_count = rsp_count_ff;

   a_start_eval: assert property (@(posedge clock) disable iff (reset)
      start |=> (state_ff == mhl_pkg::ST_ISSUE))
      else $error("Evaluation did not start after the last sample element.");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(element_count_ff) <= 32'(MAX_INPUTS))
      else $error("Element count exceeds the sample buffer depth.");

   a_rsp_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == mhl_pkg::ST_FINISH))
      else $error("Response raised outside the finishing step.");

   a_node_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff != mhl_pkg::ST_IDLE) |-> (32'(node_ff) < 32'(nodes_use)))
      else $error("Node counter ran beyond the nodes in use.");

endmodule

`default_nettype wire

// File: tb/sv/tb_mlp_hidden_layer_eval_top.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_mlp_hidden_layer_eval_top: self-checking bench for the hidden layer evaluator
// Loads weight tables and streams samples under several register settings,
// with random gaps on both channels. A scoreboard class recomputes each
// network output and violation count and checks every result transfer in order.
// ============================================================================

module tb_mlp_hidden_layer_eval_top;

   localparam int TABLE_DEPTH  = mhl_pkg::MAX_NODES_DEF * (mhl_pkg::MAX_INPUTS_DEF + 2);
   localparam int RANDOM_ITEMS = 1700;
   localparam int CALM_AFTER   = 1450;
   localparam longint OUT_MAX  = (longint'(1) <<< (mhl_pkg::OUT_W - 1)) - 1;
   localparam longint OUT_MIN  = -(longint'(1) <<< (mhl_pkg::OUT_W - 1));
   localparam longint ARG_EDGE = longint'(1) <<< (mhl_pkg::ARG_SPAN_LOG - 1);

   typedef struct {
      logic                               command;
      logic [mhl_pkg::WIDX_W-1:0]         weight_index;
      logic signed [mhl_pkg::VALUE_W-1:0] weight_value;
      logic signed [mhl_pkg::VALUE_W-1:0] sample_value;
      logic                               last_element;
   } layer_request_type;

   typedef struct {
      logic signed [mhl_pkg::OUT_W-1:0] network_output;
      logic [mhl_pkg::VCNT_W-1:0]       violation_count;
   } layer_response_type;

   class hidden_layer_checker;
      logic signed [mhl_pkg::VALUE_W-1:0] weight_words [TABLE_DEPTH];
      logic signed [mhl_pkg::VALUE_W-1:0] feature_words [mhl_pkg::MAX_INPUTS_DEF];
      longint                    sigmoid_q16 [mhl_pkg::SIGMOID_ENTRIES_DEF];
      int                        feature_count;
      int                        dimension_reg;
      int                        nodes_reg;
      int                        limit_reg;
      int                        failures;
      layer_response_type        pending_outputs [$];

      function new();
         longint      m;
         logic [63:0] mag;
         logic [63:0] f;
         logic [63:0] term;
         logic [63:0] e;
         logic [63:0] den;
         logic [63:0] num;
         logic [63:0] val;
         feature_count = 0;
         dimension_reg = mhl_pkg::DIM_RESET;
         nodes_reg     = mhl_pkg::NODES_RESET;
         limit_reg     = mhl_pkg::LIMIT_RESET;
         failures      = 0;
         for (int k = 0; k < mhl_pkg::SIGMOID_ENTRIES_DEF; k++) begin
            m    = 2 * longint'(k) + 1 - longint'(mhl_pkg::SIGMOID_ENTRIES_DEF);
            mag  = (m < 0) ? 64'(-m) : 64'(m);
            f    = (mag << 32) / 64'(mhl_pkg::SIGMOID_ENTRIES_DEF);
            term = 64'd1 << 32;
            e    = 64'd1 << 32;
            for (int t = 1; t <= 30; t++) begin
               term = q32_product(term, f) / 64'(t);
               e    = e + term;
            end
            repeat (3) e = q32_product(e, e);
            den = e + (64'd1 << 32);
            num = (m > 0) ? e : (64'd1 << 32);
            val = (num * 64'd65536 + den / 64'd2) / den;
            sigmoid_q16[k] = (val > 64'd65535) ? 65535 : longint'(val);
         end
      endfunction

      static function int clamp_count(input int v, input int hi);
         if (v < 1) return 1;
         return (v > hi) ? hi : v;
      endfunction

      function logic [63:0] q32_product(input logic [63:0] a, input logic [63:0] b);
         logic [63:0] ah;
         logic [63:0] al;
         logic [63:0] bh;
         logic [63:0] bl;
         ah = a >> 32;
         al = a & 64'hFFFF_FFFF;
         bh = b >> 32;
         bl = b & 64'hFFFF_FFFF;
         return ((ah * bh) << 32) + ah * bl + al * bh + ((al * bl) >> 32);
      endfunction

      function void write_register(input logic [mhl_pkg::CSR_IDX_W-1:0] idx,
                                   input logic [mhl_pkg::CSR_DATA_W-1:0] data);
         case (idx)
            mhl_pkg::CSR_DIMENSION: dimension_reg = data[mhl_pkg::DIM_W-1:0];
            mhl_pkg::CSR_NODES:     nodes_reg     = data[mhl_pkg::DIM_W-1:0];
            mhl_pkg::CSR_LIMIT:     limit_reg     = data[mhl_pkg::LIMIT_W-1:0];
            default: ;
         endcase
      endfunction

      function layer_response_type evaluate_network();
         layer_response_type res;
         int              d;
         int              n;
         int              base;
         int              slot;
         longint          arg;
         longint          arg_mag;
         longint          limit_q24;
         longint          sum;
         longint          scaled;
         d = clamp_count(dimension_reg, mhl_pkg::MAX_INPUTS_DEF);
         n = clamp_count(nodes_reg, mhl_pkg::MAX_NODES_DEF);
         limit_q24 = longint'(limit_reg) * 4096;
         sum = 0;
         res.violation_count = '0;
         for (int i = 0; i < n; i++) begin
            base = i * (d + 2);
            arg = longint'(weight_words[base + d + 1]) * 4096;
            for (int j = 0; j < d; j++) begin
               arg += longint'(weight_words[base + 1 + j]) * longint'(feature_words[j]);
            end
            arg_mag = (arg < 0) ? -arg : arg;
            if (arg_mag >= limit_q24) res.violation_count++;
            if (arg < -ARG_EDGE) slot = 0;
            else if (arg >= ARG_EDGE) slot = mhl_pkg::SIGMOID_ENTRIES_DEF - 1;
            else slot = int'(((arg + ARG_EDGE) * mhl_pkg::SIGMOID_ENTRIES_DEF)
                             >>> mhl_pkg::ARG_SPAN_LOG);
            sum += longint'(weight_words[base]) * sigmoid_q16[slot];
         end
         scaled = sum >>> mhl_pkg::SIG_SHIFT;
         if (scaled > OUT_MAX) scaled = OUT_MAX;
         else if (scaled < OUT_MIN) scaled = OUT_MIN;
         res.network_output = scaled[mhl_pkg::OUT_W-1:0];
         return res;
      endfunction

      function void absorb_request(input layer_request_type r);
         if (r.command == mhl_pkg::CMD_WEIGHT) begin
            if (r.weight_index < TABLE_DEPTH) weight_words[r.weight_index] = r.weight_value;
            return;
         end
         if (feature_count < mhl_pkg::MAX_INPUTS_DEF) begin
            feature_words[feature_count] = r.sample_value;
            feature_count++;
         end
         if (r.last_element) begin
            feature_count = 0;
            pending_outputs.push_back(evaluate_network());
         end
      endfunction

      function void compare_output(input logic signed [mhl_pkg::OUT_W-1:0] got_output,
                                   input logic [mhl_pkg::VCNT_W-1:0] got_count);
         layer_response_type want;
         if (pending_outputs.size() == 0) begin
            $display("%0t: result transfer with none expected: output %0d count %0d",
                     $time, got_output, got_count);
            failures++;
            return;
         end
         want = pending_outputs.pop_front();
         if (got_output !== want.network_output) begin
            $display("%0t: network_output expected %0d actual %0d",
                     $time, want.network_output, got_output);
            failures++;
         end
         if (got_count !== want.violation_count) begin
            $display("%0t: violation_count expected %0d actual %0d",
                     $time, want.violation_count, got_count);
            failures++;
         end
      endfunction
   endclass

   logic                           clock = 1'b0;
   logic                           reset;
   logic                           csr_wr_en;
   logic [mhl_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [mhl_pkg::CSR_DATA_W-1:0] csr_wdata;

   mhl_req_if req_if ();
   mhl_rsp_if rsp_if ();

   hidden_layer_checker layer_check;
   bit                  loaded_words [TABLE_DEPTH];
   int                  idle_pct     = 25;
   bit                  calm         = 1'b0;
   int                  stall_left   = 0;
   int                  random_items = 0;

   mlp_hidden_layer_eval_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_if.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < idle_pct) begin
         stall_left = $urandom_range(0, 7);
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         layer_check.compare_output(rsp_if.network_output, rsp_if.violation_count);
      end
   end

   function automatic logic [mhl_pkg::VALUE_W-1:0] pick_value(input int span);
      case ($urandom_range(0, 9))
         0:       return 16'h7FFF;
         1:       return 16'h8000;
         2, 3, 4: return 16'($urandom);
         default: return 16'($urandom_range(0, 2 * span) - span);
      endcase
   endfunction

   task automatic transfer_request(input layer_request_type r);
      int gap;
      if (!calm && $urandom_range(0, 99) < idle_pct) begin
         gap = $urandom_range(1, 8);
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid        <= 1'b1;
      req_if.command      <= r.command;
      req_if.weight_index <= r.weight_index;
      req_if.weight_value <= r.weight_value;
      req_if.sample_value <= r.sample_value;
      req_if.last_element <= r.last_element;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      layer_check.absorb_request(r);
      @(negedge clock);
   endtask

   task automatic send_weight(input int idx, input logic [mhl_pkg::VALUE_W-1:0] value);
      layer_request_type r;
      r.command      = mhl_pkg::CMD_WEIGHT;
      r.weight_index = mhl_pkg::WIDX_W'(idx);
      r.weight_value = value;
      r.sample_value = mhl_pkg::VALUE_W'($urandom);
      r.last_element = 1'($urandom_range(0, 1));
      if (idx < TABLE_DEPTH) loaded_words[idx] = 1'b1;
      transfer_request(r);
   endtask

   task automatic send_element(input logic [mhl_pkg::VALUE_W-1:0] value, input logic last);
      layer_request_type r;
      r.command      = mhl_pkg::CMD_SAMPLE;
      r.weight_index = mhl_pkg::WIDX_W'($urandom);
      r.weight_value = mhl_pkg::VALUE_W'($urandom);
      r.sample_value = value;
      r.last_element = last;
      transfer_request(r);
   endtask

   task automatic wait_idle();
      req_if.valid <= 1'b0;
      while (layer_check.pending_outputs.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic program_registers(input int dim, input int nodes, input int limit);
      logic [mhl_pkg::CSR_DATA_W-1:0] word [3];
      logic [mhl_pkg::CSR_IDX_W-1:0]  which [3];
      word[0]  = {10'($urandom), 5'(dim)};
      word[1]  = {10'($urandom), 5'(nodes)};
      word[2]  = 15'(limit);
      which[0] = mhl_pkg::CSR_DIMENSION;
      which[1] = mhl_pkg::CSR_NODES;
      which[2] = mhl_pkg::CSR_LIMIT;
      for (int k = 0; k < 3; k++) begin
         csr_wr_en <= 1'b1;
         csr_index <= which[k];
         csr_wdata <= word[k];
         @(posedge clock);
         layer_check.write_register(which[k], word[k]);
         @(negedge clock);
      end
      csr_wr_en <= 1'b0;
   endtask

   task automatic run_phase(input int dim, input int nodes, input int limit);
      int d;
      int n;
      int region;
      int phase_end;
      int pick;
      int len;
      program_registers(dim, nodes, limit);
      d = hidden_layer_checker::clamp_count(dim, mhl_pkg::MAX_INPUTS_DEF);
      n = hidden_layer_checker::clamp_count(nodes, mhl_pkg::MAX_NODES_DEF);
      region = n * (d + 2);
      idle_pct = 25 * $urandom_range(0, 2);
      for (int k = 0; k < region; k++) begin
         if (!loaded_words[k]) begin
            send_weight(k, pick_value(2048));
            random_items++;
         end
      end
      phase_end = random_items + $urandom_range(80, 200);
      while (random_items < phase_end) begin
         pick = $urandom_range(0, 99);
         if (pick < 10) begin
            send_weight($urandom_range(0, region - 1), pick_value(2048));
            random_items++;
         end else if (pick < 14) begin
            send_weight($urandom_range(TABLE_DEPTH, (1 << mhl_pkg::WIDX_W) - 1),
                        mhl_pkg::VALUE_W'($urandom));
         end else begin
            if (pick < 24) len = $urandom_range(1, d);
            else if (pick < 30) len = $urandom_range(d + 1, mhl_pkg::MAX_INPUTS_DEF + 4);
            else len = d;
            for (int el = 1; el <= len; el++) begin
               if ($urandom_range(0, 19) == 0) begin
                  send_weight($urandom_range(0, region - 1), pick_value(2048));
                  random_items++;
               end
               send_element(pick_value(8192), el == len);
               random_items++;
            end
         end
         if (random_items >= CALM_AFTER) calm = 1'b1;
      end
      wait_idle();
   endtask

   initial begin : stimulus
      int phase;
      int limit;
      layer_check         = new();
      reset               = 1'b1;
      req_if.valid        = 1'b0;
      req_if.command      = mhl_pkg::CMD_WEIGHT;
      req_if.weight_index = '0;
      req_if.weight_value = '0;
      req_if.sample_value = '0;
      req_if.last_element = 1'b0;
      rsp_if.ready        = 1'b0;
      csr_wr_en           = 1'b0;
      csr_index           = mhl_pkg::CSR_DIMENSION;
      csr_wdata           = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset geometry of one feature and one node.
      send_weight(0, 16'h7FFF);
      send_weight(1, 16'h1000);
      send_weight(2, 16'h0000);
      send_weight(511, 16'h8000);
      send_element(16'h7FFF, 1'b1);
      send_element(16'h8000, 1'b1);
      // Seventeen elements: the last one is dropped but still starts evaluation.
      for (int k = 0; k < mhl_pkg::MAX_INPUTS_DEF; k++) send_element(pick_value(8192), 1'b0);
      send_element(16'h5555, 1'b1);
      wait_idle();

      // A short sample reuses the second feature left in the buffer.
      program_registers(2, 1, 0);
      send_weight(2, 16'h8000);
      send_weight(3, 16'h7FFF);
      send_element(16'h0001, 1'b1);
      wait_idle();

      phase = 0;
      while (random_items < RANDOM_ITEMS) begin
         case ($urandom_range(0, 3))
            0:       limit = 0;
            1:       limit = (1 << mhl_pkg::LIMIT_W) - 1;
            2:       limit = $urandom_range(0, 16383);
            default: limit = $urandom_range(0, (1 << mhl_pkg::LIMIT_W) - 1);
         endcase
         case (phase)
            0: run_phase(16, 16, (1 << mhl_pkg::LIMIT_W) - 1);
            1: run_phase(1, 1, 0);
            2: run_phase(0, 31, limit);
            3: run_phase(31, 0, limit);
            4: run_phase(1, 16, limit);
            default: begin
               if ($urandom_range(0, 9) == 0) run_phase($urandom_range(0, 31),
                                                        $urandom_range(0, 31), limit);
               else run_phase($urandom_range(1, 16), $urandom_range(1, 16), limit);
            end
         endcase
         phase++;
      end

      repeat (20) @(negedge clock);
      if (layer_check.failures == 0) begin
         $display("** mlp_hidden_layer_eval_top: PASSED **");
      end else begin
         $display("** mlp_hidden_layer_eval_top: FAILED **");
      end
      $finish;
   end

   initial begin : watchdog
      #40_000_000;
      $display("** mlp_hidden_layer_eval_top: FAILED **");
      $finish;
   end

endmodule

// File: files.f
sv/mhl_pkg.sv
sv/mhl_req_if.sv
sv/mhl_rsp_if.sv
sv/mhl_weight_ram.sv
sv/mhl_sigmoid_rom.sv
sv/mhl_mac_unit.sv
sv/mlp_hidden_layer_eval_top.sv
tb/sv/tb_mlp_hidden_layer_eval_top.sv
